>>> sv/six_axis_jog_positioner_defines.svh
// Assertion macros for the six-axis jog positioner.
`ifndef SIX_AXIS_JOG_POSITIONER_DEFINES_SVH
`define SIX_AXIS_JOG_POSITIONER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SJP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SJP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sjp_pkg.sv
// Shared types, constants and helper functions of the jog positioner.
`default_nettype none

package sjp_pkg;

	localparam int AXIS_COUNT = 6;
	localparam int SETUP_AXES = 6;
	localparam int AXIS_W     = 3;
	localparam int AXIS_IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int WRAP_IDX_W = $clog2(SETUP_AXES);
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int SETUP_W    = 62;
	localparam int BND_W      = 12;
	localparam int STEP_W     = 10;
	localparam int MULT_W     = 8;
	localparam int DET_W      = STEP_W + MULT_W;
	localparam int POS_W      = 14;
	localparam int OUT_W      = 12;
	// working value: position +/- detent +/- one bound, with margin
	localparam int VAL_W      = 20;
	localparam int MAG_W      = 20;
	localparam int DIV_ITER   = MAG_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_ITER);

	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MASK = 3'd6;
	localparam logic [SETUP_AXES-1:0] WRAP_RESET   = 6'd7;

	localparam logic [SETUP_W-1:0] SETUP_RESET [SETUP_AXES] = '{
		62'd811000120246435840, 62'd811000120246435840, 62'd811000120246435840,
		62'd811001151040392416, 62'd811001151040392416, 62'd811001164465848420
	};

	typedef enum logic [OP_W-1:0] {
		OP_START    = 3'd0,
		OP_STEP_UP  = 3'd1,
		OP_STEP_DN  = 3'd2,
		OP_MINOR_UP = 3'd3,
		OP_MINOR_DN = 3'd4,
		OP_MAJOR_UP = 3'd5,
		OP_MAJOR_DN = 3'd6,
		OP_LOAD     = 3'd7
	} op_t;

	typedef struct packed {
		logic [MULT_W-1:0]       major;
		logic [MULT_W-1:0]       minor;
		logic [STEP_W-1:0]       step;
		logic signed [BND_W-1:0] start;
		logic signed [BND_W-1:0] maxv;
		logic signed [BND_W-1:0] minv;
	} setup_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FETCH = 8'b0000_0010,
		ST_MULT  = 8'b0000_0100,
		ST_APPLY = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_TRUNC = 8'b0010_0000,
		ST_BOUND = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic capture;
		logic fetch;
		logic mult;
		logic apply;
		logic trunc;
		logic bound;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_stat_t;

	localparam logic signed [VAL_W-1:0] POS_HI = VAL_W'((1 <<< (POS_W - 1)) - 1);
	localparam logic signed [VAL_W-1:0] POS_LO = VAL_W'(-(1 <<< (POS_W - 1)));
	localparam logic signed [POS_W-1:0] OUT_HI = POS_W'((1 <<< (OUT_W - 1)) - 1);
	localparam logic signed [POS_W-1:0] OUT_LO = POS_W'(-(1 <<< (OUT_W - 1)));

	function automatic logic is_detent(input op_t op);
		return (op == OP_MINOR_UP) || (op == OP_MINOR_DN) ||
			(op == OP_MAJOR_UP) || (op == OP_MAJOR_DN);
	endfunction

	function automatic logic signed [POS_W-1:0] start_pos(input setup_t s);
		return POS_W'(s.start);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VAL_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_HI)
			r = POS_HI[POS_W-1:0];
		else if (v < POS_LO)
			r = POS_LO[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > OUT_HI)
			r = OUT_HI[OUT_W-1:0];
		else if (v < OUT_LO)
			r = OUT_LO[OUT_W-1:0];
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/sjp_if.sv
// Valid/ready channel interfaces for jog commands and position results.
`default_nettype none

interface sjp_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [sjp_pkg::OP_W-1:0]            operation;
	logic [sjp_pkg::AXIS_W-1:0]          axis_select;
	logic signed [sjp_pkg::BND_W-1:0]    load_value;

	modport source (output valid, output operation, output axis_select,
		output load_value, input ready);
	modport sink (input valid, input operation, input axis_select,
		input load_value, output ready);
endinterface

interface sjp_res_if;
	logic                                valid;
	logic                                ready;
	logic [sjp_pkg::AXIS_W-1:0]          moved_axis;
	logic signed [sjp_pkg::OUT_W-1:0]    new_position;

	modport source (output valid, output moved_axis, output new_position, input ready);
	modport sink (input valid, input moved_axis, input new_position, output ready);
endinterface

`default_nettype wire

>>> sv/sjp_div.sv
// Radix-4 restoring divider that yields the remainder of a magnitude.
`default_nettype none

module sjp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sjp_pkg::MAG_W-1:0]        dividend,
	input  logic [sjp_pkg::DET_W-1:0]        divisor,
	output logic                             done,
	output logic [sjp_pkg::DET_W-1:0]        remainder
);

	logic                             busy_q;
	logic [sjp_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [sjp_pkg::MAG_W-1:0]        quo_q;
	logic [sjp_pkg::DET_W-1:0]        rem_q;
	logic [sjp_pkg::DET_W-1:0]        rem_nx;
	logic                             last;

	assign last      = cnt_q == sjp_pkg::DIV_CNT_W'(sjp_pkg::DIV_ITER - 1);
	assign done      = busy_q && last;
	assign remainder = rem_q;

	// two shift/compare/subtract steps per cycle
	always_comb begin
		logic [sjp_pkg::DET_W:0] r;
		rem_nx = rem_q;
		for (int i = 0; i < 2; i++) begin
			r = {rem_nx, quo_q[sjp_pkg::MAG_W-1-i]};
			if (r >= {1'b0, divisor})
				r = r - {1'b0, divisor};
			rem_nx = r[sjp_pkg::DET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[sjp_pkg::MAG_W-3:0], 2'b00};
			rem_q <= rem_nx;
		end
	end

endmodule

`default_nettype wire

>>> sv/sjp_dp.sv
// Datapath: axis settings and positions, detent arithmetic, bounds, result register.
`default_nettype none

module sjp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sjp_pkg::dp_cmd_t                   cmd,
	output sjp_pkg::dp_stat_t                  stat,
	input  logic                               cfg_write,
	input  logic [sjp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sjp_pkg::SETUP_W-1:0]        cfg_data,
	input  logic [sjp_pkg::OP_W-1:0]           operation,
	input  logic [sjp_pkg::AXIS_W-1:0]         axis_select,
	input  logic signed [sjp_pkg::BND_W-1:0]   load_value,
	output logic [sjp_pkg::AXIS_W-1:0]         moved_axis,
	output logic signed [sjp_pkg::OUT_W-1:0]   new_position
);

	localparam int VW = sjp_pkg::VAL_W;

	sjp_pkg::setup_t                    setup_q [sjp_pkg::AXIS_COUNT];
	logic signed [sjp_pkg::POS_W-1:0]   pos_q [sjp_pkg::AXIS_COUNT];
	logic [sjp_pkg::SETUP_AXES-1:0]     wrap_q;

	sjp_pkg::op_t                       op_q;
	logic [sjp_pkg::AXIS_W-1:0]         sel_q;
	logic signed [sjp_pkg::BND_W-1:0]   load_q;
	logic signed [sjp_pkg::BND_W-1:0]   mn_q;
	logic signed [sjp_pkg::BND_W-1:0]   mx_q;
	logic signed [sjp_pkg::BND_W-1:0]   st_q;
	logic [sjp_pkg::STEP_W-1:0]         step_q;
	logic [sjp_pkg::MULT_W-1:0]         mult_q;
	logic                               wraps_q;
	logic                               oor_q;
	logic signed [sjp_pkg::POS_W-1:0]   cur_q;
	logic [sjp_pkg::DET_W-1:0]          det_q;
	logic signed [VW-1:0]               val_q;
	logic                               neg_q;
	logic                               trunc_q;
	logic signed [sjp_pkg::POS_W-1:0]   fin_q;
	logic [sjp_pkg::AXIS_W-1:0]         moved_axis_q;
	logic signed [sjp_pkg::OUT_W-1:0]   new_position_q;

	logic                               sel_ok;
	logic [sjp_pkg::AXIS_IDX_W-1:0]     sel_idx;
	sjp_pkg::setup_t                    fsel;
	logic signed [sjp_pkg::POS_W-1:0]   fpos;
	logic                               fwrap;

	logic signed [VW-1:0]               mn_ext;
	logic signed [VW-1:0]               mx_ext;
	logic signed [VW-1:0]               v1;
	logic signed [VW-1:0]               vt;
	logic signed [VW-1:0]               vb;
	logic [sjp_pkg::MAG_W-1:0]          mag;
	logic [sjp_pkg::DET_W-1:0]          rem;
	logic                               div_start;

	// ---- settings and positions ----
	for (genvar a = 0; a < sjp_pkg::AXIS_COUNT; a++) begin : g_axis
		if (a < sjp_pkg::SETUP_AXES) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					setup_q[a] <= sjp_pkg::setup_t'(sjp_pkg::SETUP_RESET[a]);
				else if (cfg_write && cfg_index == sjp_pkg::CFG_IDX_W'(a))
					setup_q[a] <= sjp_pkg::setup_t'(cfg_data);
			end
		end else begin : g_fixed
			assign setup_q[a] = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				if (a < sjp_pkg::SETUP_AXES)
					pos_q[a] <= sjp_pkg::start_pos(
						sjp_pkg::setup_t'(sjp_pkg::SETUP_RESET[a % sjp_pkg::SETUP_AXES]));
				else
					pos_q[a] <= '0;
			end else if (cfg_write && cfg_index == sjp_pkg::CFG_IDX_W'(a) &&
					a < sjp_pkg::SETUP_AXES) begin
				// setup write also homes the axis
				pos_q[a] <= sjp_pkg::start_pos(sjp_pkg::setup_t'(cfg_data));
			end else if (cmd.commit && sel_ok && sel_idx == sjp_pkg::AXIS_IDX_W'(a)) begin
				pos_q[a] <= fin_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wrap_q <= sjp_pkg::WRAP_RESET;
		else if (cfg_write && cfg_index == sjp_pkg::REG_WRAP_MASK)
			wrap_q <= cfg_data[sjp_pkg::SETUP_AXES-1:0];
	end

	// ---- fetch ----
	assign sel_ok  = {1'b0, sel_q} < (sjp_pkg::AXIS_W + 1)'(sjp_pkg::AXIS_COUNT);
	assign sel_idx = sel_q[sjp_pkg::AXIS_IDX_W-1:0];
	assign fsel    = sel_ok ? setup_q[sel_idx] : '0;
	assign fpos    = sel_ok ? pos_q[sel_idx] : '0;
	assign fwrap   = sel_ok && (sel_q < sjp_pkg::AXIS_W'(sjp_pkg::SETUP_AXES)) &&
		wrap_q[sel_q[sjp_pkg::WRAP_IDX_W-1:0]];

	// ---- move ----
	assign mn_ext = VW'(mn_q);
	assign mx_ext = VW'(mx_q);

	always_comb begin
		logic signed [VW-1:0] cur_ext;
		logic signed [VW-1:0] step_ext;
		logic signed [VW-1:0] det_ext;
		cur_ext  = VW'(cur_q);
		step_ext = VW'(step_q);
		det_ext  = VW'(det_q);
		case (op_q)
			sjp_pkg::OP_START:    v1 = VW'(st_q);
			sjp_pkg::OP_STEP_UP:  v1 = cur_ext + step_ext;
			sjp_pkg::OP_STEP_DN:  v1 = cur_ext - step_ext;
			sjp_pkg::OP_LOAD:     v1 = VW'(load_q);
			sjp_pkg::OP_MINOR_UP,
			sjp_pkg::OP_MAJOR_UP: v1 = cur_ext + det_ext;
			sjp_pkg::OP_MINOR_DN,
			sjp_pkg::OP_MAJOR_DN: begin
				v1 = cur_ext - det_ext;
				if (v1 < mn_ext && wraps_q)
					v1 = v1 + mx_ext;
			end
			default:              v1 = cur_ext;
		endcase
		mag = sjp_pkg::MAG_W'(v1[VW-1] ? -v1 : v1);
	end

	assign stat.need_div = sjp_pkg::is_detent(op_q) && (det_q != '0);
	assign div_start     = cmd.apply && stat.need_div;

	sjp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag),
		.divisor   (det_q),
		.done      (stat.div_done),
		.remainder (rem)
	);

	// truncate toward zero, then the lower bound
	always_comb begin
		logic signed [VW-1:0] rem_ext;
		rem_ext = VW'(rem);
		vt = val_q;
		if (trunc_q)
			vt = neg_q ? val_q + rem_ext : val_q - rem_ext;
		if (vt < mn_ext)
			vt = wraps_q ? vt + mx_ext : mn_ext;
	end

	// upper bound
	always_comb begin
		vb = val_q;
		if (val_q > mx_ext)
			vb = wraps_q ? val_q - mx_ext : mx_ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= sjp_pkg::op_t'(operation);
			sel_q  <= axis_select;
			load_q <= load_value;
		end
		if (cmd.fetch) begin
			mn_q    <= fsel.minv;
			mx_q    <= fsel.maxv;
			st_q    <= fsel.start;
			step_q  <= fsel.step;
			mult_q  <= (op_q == sjp_pkg::OP_MINOR_UP || op_q == sjp_pkg::OP_MINOR_DN) ?
				fsel.minor : fsel.major;
			wraps_q <= fwrap;
			oor_q   <= !sel_ok;
			cur_q   <= fpos;
		end
		if (cmd.mult)
			det_q <= sjp_pkg::DET_W'(step_q) * sjp_pkg::DET_W'(mult_q);
		if (cmd.apply) begin
			val_q   <= v1;
			neg_q   <= v1[VW-1];
			trunc_q <= stat.need_div;
		end
		if (cmd.trunc)
			val_q <= vt;
		if (cmd.bound)
			fin_q <= sjp_pkg::sat_pos(vb);
		if (cmd.commit) begin
			moved_axis_q   <= sel_q;
			new_position_q <= oor_q ? '0 : sjp_pkg::sat_out(fin_q);
		end
	end

	assign moved_axis   = moved_axis_q;
	assign new_position = new_position_q;

endmodule

`default_nettype wire

>>> sv/sjp_ctrl.sv
// Controller: sequences one jog word through the datapath and owns the handshakes.
`default_nettype none

`include "six_axis_jog_positioner_defines.svh"

module sjp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	output sjp_pkg::dp_cmd_t     dp_cmd,
	input  sjp_pkg::dp_stat_t    stat
);

	sjp_pkg::state_t state_q;
	sjp_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || res_ready;
	assign cmd_ready = state_q == sjp_pkg::ST_IDLE;
	assign res_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			sjp_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.capture = 1'b1;
					state_d        = sjp_pkg::ST_FETCH;
				end
			end
			sjp_pkg::ST_FETCH: begin
				dp_cmd.fetch = 1'b1;
				state_d      = sjp_pkg::ST_MULT;
			end
			sjp_pkg::ST_MULT: begin
				dp_cmd.mult = 1'b1;
				state_d     = sjp_pkg::ST_APPLY;
			end
			sjp_pkg::ST_APPLY: begin
				dp_cmd.apply = 1'b1;
				state_d      = stat.need_div ? sjp_pkg::ST_DIV : sjp_pkg::ST_TRUNC;
			end
			sjp_pkg::ST_DIV: begin
				if (stat.div_done)
					state_d = sjp_pkg::ST_TRUNC;
			end
			sjp_pkg::ST_TRUNC: begin
				dp_cmd.trunc = 1'b1;
				state_d      = sjp_pkg::ST_BOUND;
			end
			sjp_pkg::ST_BOUND: begin
				dp_cmd.bound = 1'b1;
				state_d      = sjp_pkg::ST_OUT;
			end
			sjp_pkg::ST_OUT: begin
				// hold until the result register is free
				if (out_free) begin
					dp_cmd.commit = 1'b1;
					state_d       = sjp_pkg::ST_IDLE;
				end
			end
			default: state_d = sjp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sjp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.commit)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	`SJP_ASSERT_NEXT(a_accept_fetch, cmd_valid && cmd_ready, state_q == sjp_pkg::ST_FETCH, "accepted word did not start a fetch")
	`SJP_ASSERT_NEXT(a_commit_shown, dp_cmd.commit, res_valid, "committed result not presented")
	`SJP_ASSERT_NOW(a_no_overwrite, dp_cmd.commit && out_valid_q, res_ready, "pending result overwritten")
	`SJP_ASSERT_NOW(a_div_needed, state_q == sjp_pkg::ST_DIV, stat.need_div, "divider wait without a detent move")

endmodule

`default_nettype wire

>>> sv/six_axis_jog_positioner.sv
// Six-axis jog positioner: a jog word in, the moved axis and its new position out.
// Each accepted word is handled alone. Steps, loads, return-to-start, detent moves with a zero
// detent and words for an axis that does not exist skip the divider. Other detent moves pass
// through the radix-4 remainder divider, which truncates the value to a multiple of the detent.
// The steps around it are fetch, multiply and apply, then truncate, bound and result load. The
// result sits in an output register, so the next word is taken while an earlier result waits.
// That next word then holds in its result-load step until the earlier result is taken. Writing
// an axis setup register also returns that axis to its new start; the user must write
// configuration only while no word is in flight, and the block itself does not enforce this.
`default_nettype none

module six_axis_jog_positioner (
	input  logic                               clk,
	input  logic                               arst_n,
	sjp_cmd_if.sink                            cmd,
	sjp_res_if.source                          res,
	input  logic                               cfg_write,
	input  logic [sjp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sjp_pkg::SETUP_W-1:0]        cfg_data
);

	sjp_pkg::dp_cmd_t  dp_cmd;
	sjp_pkg::dp_stat_t dp_stat;
	logic              cmd_ready;
	logic              res_valid;

	assign cmd.ready = cmd_ready;
	assign res.valid = res_valid;

	sjp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.dp_cmd    (dp_cmd),
		.stat      (dp_stat)
	);

	sjp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (cmd.operation),
		.axis_select  (cmd.axis_select),
		.load_value   (cmd.load_value),
		.moved_axis   (res.moved_axis),
		.new_position (res.new_position)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking bench for the six-axis jog positioner: predicted positions against the result channel.
module tb;
	import sjp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_VANTAGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORBIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRAB    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOOM    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOLLY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 165;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [AXIS_W-1:0]       axis;
		logic signed [OUT_W-1:0] pos;
	} move_result_t;

	class position_tracker;
		setup_t                  setups [SETUP_AXES];
		logic [SETUP_AXES-1:0]   wrap;
		logic signed [POS_W-1:0] pos [AXIS_COUNT];
		move_result_t            expected_moves [$];
		int                      mismatches;
		int                      reported;
		int                      checked;

		function new();
			for (int a = 0; a < AXIS_COUNT; a++) begin
				setups[a] = SETUP_RESET[a];
				pos[a] = POS_W'(setups[a].start);
			end
			wrap = WRAP_RESET;
			mismatches = 0;
			reported = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SETUP_W-1:0] data);
			if (idx < SETUP_AXES) begin
				setups[idx] = data;
				pos[idx] = POS_W'(setups[idx].start);
			end else if (idx == REG_WRAP_MASK) begin
				wrap = data[SETUP_AXES-1:0];
			end
		endfunction

		function void note_jog(op_t op, logic [AXIS_W-1:0] sel, logic signed [BND_W-1:0] load);
			setup_t       s;
			int           mn, mx, st, step, mult, det, v;
			bit           wraps;
			move_result_t r;
			r.axis = sel;
			r.pos = '0;
			if (sel >= AXIS_COUNT) begin
				expected_moves.push_back(r);
				return;
			end
			s = setups[sel];
			mn = int'(s.minv);
			mx = int'(s.maxv);
			st = int'(s.start);
			step = int'({1'b0, s.step});
			wraps = wrap[sel];
			v = int'(pos[sel]);
			case (op)
				OP_START:   v = st;
				OP_STEP_UP: v = v + step;
				OP_STEP_DN: v = v - step;
				OP_LOAD:    v = int'(load);
				default: begin
					mult = (op == OP_MINOR_UP || op == OP_MINOR_DN) ?
						int'({1'b0, s.minor}) : int'({1'b0, s.major});
					det = step * mult;
					if (op == OP_MINOR_DN || op == OP_MAJOR_DN) begin
						v = v - det;
						// wrap axes get one add of max on the way down
						if (v < mn && wraps)
							v = v + mx;
					end else begin
						v = v + det;
					end
					if (det != 0)
						v = v - (v % det);
				end
			endcase
			if (!wraps) begin
				if (v < mn) v = mn;
				if (v > mx) v = mx;
			end else begin
				if (v < mn) v = v + mx;
				if (v > mx) v = v - mx;
			end
			if (v > 8191) v = 8191;
			if (v < -8192) v = -8192;
			pos[sel] = POS_W'(v);
			if (v > 2047) v = 2047;
			if (v < -2048) v = -2048;
			r.pos = OUT_W'(v);
			expected_moves.push_back(r);
		endfunction

		function void check_result(logic [AXIS_W-1:0] axis, logic signed [OUT_W-1:0] npos);
			move_result_t e;
			checked++;
			if (expected_moves.size() == 0) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("tb: unexpected result axis=%0d pos=%0d", axis, npos);
				end
				return;
			end
			e = expected_moves.pop_front();
			if (axis !== e.axis || npos !== e.pos) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("tb: mismatch axis exp=%0d got=%0d, pos exp=%0d got=%0d",
						e.axis, axis, e.pos, npos);
				end
			end
		endfunction

		function int pending();
			return expected_moves.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SETUP_W-1:0]    cfg_data;

	sjp_cmd_if cmd ();
	sjp_res_if res ();

	six_axis_jog_positioner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	position_tracker tracker = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// result side: check, then pick ready for the next edge
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				tracker.check_result(res.moved_axis, res.new_position);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic setup_t pack_setup(int mn, int mx, int st, int stp, int mi, int ma);
		setup_t s;
		s.minv = BND_W'(mn);
		s.maxv = BND_W'(mx);
		s.start = BND_W'(st);
		s.step = STEP_W'(stp);
		s.minor = MULT_W'(mi);
		s.major = MULT_W'(ma);
		return s;
	endfunction

	function automatic setup_t random_setup(bit raw);
		logic [63:0] r;
		int          mn, mx;
		if (raw) begin
			r = {$urandom(), $urandom()};
			return r[SETUP_W-1:0];
		end
		mn = -int'($urandom_range(1500, 0));
		mx = int'($urandom_range(2047, 1));
		return pack_setup(mn, mx, mn + int'($urandom_range(mx - mn)),
			($urandom_range(9) < 7) ? int'($urandom_range(40, 1)) : int'($urandom_range(1023)),
			int'($urandom_range(16)), int'($urandom_range(255)));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SETUP_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task automatic end_writes;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_jog(input op_t op, input logic [AXIS_W-1:0] sel,
			input logic signed [BND_W-1:0] load);
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.axis_select <= sel;
		cmd.load_value <= load;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		tracker.note_jog(op, sel, load);
		words_sent++;
	endtask

	task automatic sender_gap;
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_random_jog;
		logic [AXIS_W-1:0]       sel;
		logic signed [BND_W-1:0] load;
		sel = ($urandom_range(99) < 4) ? AXIS_W'($urandom_range(7, 6)) :
			AXIS_W'($urandom_range(AXIS_COUNT - 1));
		case ($urandom_range(3))
			0: load = BND_W'($urandom());
			1: load = BND_W'(int'($urandom_range(200)) - 100);
			2: load = ($urandom_range(1)) ? 12'sh7FF : -12'sh800;
			default: load = BND_W'($urandom());
		endcase
		send_jog(op_t'($urandom_range(7)), sel, load);
	endtask

	task automatic wait_drained;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_mode(input int p);
		case (p % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 85; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 85; end
			default: begin idle_pct = 16; stall_pct = 16; end
		endcase
	endtask

	task automatic configure(input int p);
		logic [63:0] r;
		if (p == 3) begin
			write_reg(REG_VANTAGE, '1);
			write_reg(REG_SPIN, '0);
			// min above max, zero major multiplier
			write_reg(REG_ORBIT, pack_setup(500, -500, 0, 10, 3, 0));
			// widest detent, goes past the stored range when wrapping
			write_reg(REG_CRAB, pack_setup(-2048, 2047, 0, 1023, 255, 1));
			write_reg(REG_BOOM, pack_setup(-2048, 2047, 2047, 1, 1, 255));
			write_reg(REG_DOLLY, random_setup(1'b1));
			write_reg(REG_WRAP_MASK, SETUP_W'(6'b001001));
			r = {$urandom(), $urandom()};
			write_reg(REG_UNUSED, r[SETUP_W-1:0]);
		end else begin
			for (int a = 0; a < SETUP_AXES; a++)
				write_reg(CFG_IDX_W'(a), random_setup($urandom_range(3) == 0));
			if (p == 1)
				write_reg(REG_WRAP_MASK, '0);
			else if (p == 2)
				write_reg(REG_WRAP_MASK, SETUP_W'(6'h3F));
			else
				write_reg(REG_WRAP_MASK, SETUP_W'($urandom_range(63)));
		end
		end_writes();
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.operation <= OP_START;
		cmd.axis_select <= '0;
		cmd.load_value <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every op, load extremes, axes that do not exist
		set_mode(0);
		for (int o = 1; o < 8; o++)
			send_jog(op_t'(o), 3'd0, 12'sd37);
		send_jog(OP_START, 3'd0, 12'sd0);
		send_jog(OP_LOAD, 3'd3, 12'sh7FF);
		send_jog(OP_LOAD, 3'd3, -12'sh800);
		send_jog(OP_LOAD, 3'd5, 12'sh7FF);
		send_jog(OP_LOAD, 3'd5, -12'sh800);
		send_jog(OP_MAJOR_DN, 3'd6, 12'sh555);
		send_jog(OP_MINOR_UP, 3'd7, -12'sh556);
		cmd.valid <= 1'b0;
		wait_drained();

		for (int p = 1; p <= PHASES; p++) begin
			configure(p);
			set_mode(p);
			if (p == 3) begin
				send_jog(OP_MINOR_UP, 3'd1, 12'sd0);
				send_jog(OP_MAJOR_DN, 3'd1, 12'sd0);
				send_jog(OP_STEP_UP, 3'd2, 12'sd0);
				send_jog(OP_MINOR_DN, 3'd2, 12'sd0);
				send_jog(OP_MAJOR_UP, 3'd2, 12'sd0);
				send_jog(OP_MAJOR_UP, 3'd3, 12'sd0);
				send_jog(OP_MAJOR_UP, 3'd3, 12'sd0);
				send_jog(OP_MAJOR_DN, 3'd3, 12'sd0);
				send_jog(OP_STEP_DN, 3'd0, 12'sd0);
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i == RANDOM_PER_PHASE / 2)
					hold_req = 1'b1;
				send_random_jog();
				if (i == (3 * RANDOM_PER_PHASE) / 4) begin
					cmd.valid <= 1'b0;
					do @(posedge clk); while (tracker.pending() != 0);
				end
				sender_gap();
			end
			cmd.valid <= 1'b0;
			wait_drained();
		end

		$display("tb: %0d jog words over %0d setting phases, %0d positions checked",
			words_sent, PHASES + 1, tracker.checked);
		$display("tb: all ops, axes 0-7, wrap and clamp, zero and wide detents, %0d failures",
			tracker.mismatches + tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/sjp_pkg.sv
sv/sjp_if.sv
sv/sjp_div.sv
sv/sjp_dp.sv
sv/sjp_ctrl.sv
sv/six_axis_jog_positioner.sv
test/tb.sv
